// File: hdl/nclex_pkg.sv
// shared types and constants for the nested comment and raw string lexer
package nclex_pkg;

  // default limits
  localparam int MAX_NEST_DEF = 128;
  localparam int MAX_HASH_DEF = 16;

  // character codes
  localparam logic [7:0] CH_EOF   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_R     = 8'h72;

  // result status codes
  localparam logic [1:0] ST_SCAN = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;
  localparam logic [1:0] ST_IDLE = 2'd3;

  // token kind codes
  localparam logic [1:0] KIND_CMT = 2'd0;
  localparam logic [1:0] KIND_RAW = 2'd1;
  localparam logic [1:0] KIND_ML  = 2'd2;

  // bit positions in the allowed kind mask
  localparam int MASK_CMT = 0;
  localparam int MASK_RAW = 1;
  localparam int MASK_ML  = 2;

  typedef enum logic [12:0] {
    PH_IDLE      = 13'b0000000000001,
    PH_LEAD      = 13'b0000000000010,
    PH_CMT_OPEN  = 13'b0000000000100,
    PH_CMT_BODY  = 13'b0000000001000,
    PH_CMT_SLASH = 13'b0000000010000,
    PH_CMT_STAR  = 13'b0000000100000,
    PH_RAW_HASH  = 13'b0000001000000,
    PH_RAW_OVER  = 13'b0000010000000,
    PH_RAW_BODY  = 13'b0000100000000,
    PH_RAW_CLOSE = 13'b0001000000000,
    PH_ML_OPEN   = 13'b0010000000000,
    PH_ML_BODY   = 13'b0100000000000,
    PH_ML_CLOSE  = 13'b1000000000000
  } phase_t;

  // scan control state of fixed width
  typedef struct packed {
    phase_t     phase;
    logic [1:0] token_kind;
    logic [2:0] kind_mask;
    logic [1:0] quote_run;
  } ctl_t;

  // one result item
  typedef struct packed {
    logic [1:0] status;
    logic [1:0] kind;
    logic       in_token;
    logic       skipped;
  } res_t;

endpackage

// File: hdl/nclex_step.sv
// per-character scan step: next scan state and result from current state and item
module nclex_step import nclex_pkg::*; #(
  parameter int MAX_NEST = MAX_NEST_DEF,
  parameter int MAX_HASH = MAX_HASH_DEF,
  localparam int NEST_W = $clog2(MAX_NEST + 1),
  localparam int HASH_W = $clog2(MAX_HASH + 1)
) (
  input  logic              start_scan,
  input  logic [7:0]        ch,
  input  logic [2:0]        allowed_kinds,
  input  ctl_t              cur_ctl,
  input  logic [NEST_W-1:0] cur_depth,
  input  logic [HASH_W-1:0] cur_open,
  input  logic [HASH_W-1:0] cur_close,
  output ctl_t              nxt_ctl,
  output logic [NEST_W-1:0] nxt_depth,
  output logic [HASH_W-1:0] nxt_open,
  output logic [HASH_W-1:0] nxt_close,
  output res_t              res
);

  ctl_t              e_ctl;
  logic [NEST_W-1:0] e_depth;
  logic [HASH_W-1:0] e_open;
  logic [HASH_W-1:0] e_close;
  logic [1:0]        st;
  logic              tin;
  logic              skip;
  logic              do_disp;
  logic              disp_cmt_en;
  logic              disp_raw_en;
  logic              do_cmt_body;
  logic              do_raw_body;
  logic              do_ml_body;
  logic              is_ws;

  assign is_ws = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_CR) || (ch == CH_LF);

  always_comb begin
    // a start flag restarts the scan on this character
    e_ctl   = cur_ctl;
    e_depth = cur_depth;
    e_open  = cur_open;
    e_close = cur_close;
    if (start_scan) begin
      e_ctl.kind_mask  = allowed_kinds;
      e_ctl.phase      = PH_LEAD;
      e_ctl.token_kind = KIND_CMT;
      e_ctl.quote_run  = 2'd0;
      e_depth          = '0;
      e_open           = '0;
      e_close          = '0;
    end

    nxt_ctl     = e_ctl;
    nxt_depth   = e_depth;
    nxt_open    = e_open;
    nxt_close   = e_close;
    st          = ST_SCAN;
    tin         = 1'b0;
    skip        = 1'b0;
    do_disp     = 1'b0;
    disp_cmt_en = 1'b0;
    disp_raw_en = 1'b0;
    do_cmt_body = 1'b0;
    do_raw_body = 1'b0;
    do_ml_body  = 1'b0;

    unique case (e_ctl.phase)
      PH_LEAD: begin
        if (is_ws) begin
          skip = 1'b1;
        end else begin
          do_disp     = 1'b1;
          disp_cmt_en = 1'b1;
          disp_raw_en = 1'b1;
        end
      end
      PH_CMT_OPEN: begin
        if (ch == CH_STAR) begin
          tin           = 1'b1;
          nxt_depth     = NEST_W'(1);
          nxt_ctl.phase = PH_CMT_BODY;
        end else begin
          do_disp     = 1'b1;
          disp_raw_en = 1'b1;
        end
      end
      PH_CMT_BODY: begin
        do_cmt_body = 1'b1;
      end
      PH_CMT_SLASH: begin
        if (ch == CH_STAR) begin
          tin = 1'b1;
          if (e_depth < NEST_W'(MAX_NEST)) begin
            nxt_depth = e_depth + NEST_W'(1);
          end
          nxt_ctl.phase = PH_CMT_BODY;
        end else begin
          do_cmt_body = 1'b1;
        end
      end
      PH_CMT_STAR: begin
        if (ch == CH_SLASH) begin
          if (e_depth <= NEST_W'(1)) begin
            nxt_depth     = '0;
            st            = ST_DONE;
            tin           = 1'b1;
            nxt_ctl.phase = PH_IDLE;
          end else begin
            nxt_depth     = e_depth - NEST_W'(1);
            tin           = 1'b1;
            nxt_ctl.phase = PH_CMT_BODY;
          end
        end else begin
          do_cmt_body = 1'b1;
        end
      end
      PH_RAW_HASH: begin
        if (ch == CH_HASH) begin
          tin = 1'b1;
          if (e_open < HASH_W'(MAX_HASH)) begin
            nxt_open = e_open + HASH_W'(1);
          end else begin
            nxt_ctl.phase = PH_RAW_OVER;
          end
        end else if (ch == CH_QUOTE) begin
          tin           = 1'b1;
          nxt_ctl.phase = PH_RAW_BODY;
        end else begin
          do_disp = 1'b1;
        end
      end
      PH_RAW_OVER: begin
        do_disp = 1'b1;
      end
      PH_RAW_BODY: begin
        do_raw_body = 1'b1;
      end
      PH_RAW_CLOSE: begin
        if ((e_close < e_open) && (ch == CH_HASH)) begin
          tin       = 1'b1;
          nxt_close = e_close + HASH_W'(1);
        end else if ((e_close == e_open) && (ch != CH_HASH)) begin
          st            = ST_DONE;
          nxt_ctl.phase = PH_IDLE;
        end else begin
          do_raw_body = 1'b1;
        end
      end
      PH_ML_OPEN: begin
        if (ch == CH_QUOTE) begin
          tin = 1'b1;
          if (e_ctl.quote_run >= 2'd2) begin
            nxt_ctl.phase = PH_ML_BODY;
          end else begin
            nxt_ctl.quote_run = e_ctl.quote_run + 2'd1;
          end
        end else begin
          st            = ST_NONE;
          nxt_ctl.phase = PH_IDLE;
        end
      end
      PH_ML_BODY: begin
        do_ml_body = 1'b1;
      end
      PH_ML_CLOSE: begin
        if (ch == CH_QUOTE) begin
          if (e_ctl.quote_run >= 2'd2) begin
            st            = ST_DONE;
            tin           = 1'b1;
            nxt_ctl.phase = PH_IDLE;
          end else begin
            tin               = 1'b1;
            nxt_ctl.quote_run = e_ctl.quote_run + 2'd1;
          end
        end else begin
          do_ml_body = 1'b1;
        end
      end
      default: begin
        nxt_ctl.phase = PH_IDLE;
        st            = ST_IDLE;
      end
    endcase

    // choose a token kind from the first significant character
    if (do_disp) begin
      if (disp_cmt_en && e_ctl.kind_mask[MASK_CMT] && (ch == CH_SLASH)) begin
        nxt_ctl.token_kind = KIND_CMT;
        tin                = 1'b1;
        nxt_ctl.phase      = PH_CMT_OPEN;
      end else if (disp_raw_en && e_ctl.kind_mask[MASK_RAW] && (ch == CH_R)) begin
        nxt_ctl.token_kind = KIND_RAW;
        tin                = 1'b1;
        nxt_open           = '0;
        nxt_ctl.phase      = PH_RAW_HASH;
      end else if (e_ctl.kind_mask[MASK_ML] && (ch == CH_QUOTE)) begin
        nxt_ctl.token_kind = KIND_ML;
        tin                = 1'b1;
        nxt_ctl.quote_run  = 2'd1;
        nxt_ctl.phase      = PH_ML_OPEN;
      end else begin
        st            = ST_NONE;
        tin           = 1'b0;
        nxt_ctl.phase = PH_IDLE;
      end
    end

    // token bodies: end of input closes the token without the character
    if (do_cmt_body) begin
      if (ch == CH_EOF) begin
        st            = ST_DONE;
        nxt_ctl.phase = PH_IDLE;
      end else begin
        tin = 1'b1;
        if (ch == CH_SLASH) begin
          nxt_ctl.phase = PH_CMT_SLASH;
        end else if (ch == CH_STAR) begin
          nxt_ctl.phase = PH_CMT_STAR;
        end else begin
          nxt_ctl.phase = PH_CMT_BODY;
        end
      end
    end

    if (do_raw_body) begin
      if (ch == CH_EOF) begin
        st            = ST_DONE;
        nxt_ctl.phase = PH_IDLE;
      end else begin
        tin = 1'b1;
        if (ch == CH_QUOTE) begin
          nxt_close     = '0;
          nxt_ctl.phase = PH_RAW_CLOSE;
        end else begin
          nxt_ctl.phase = PH_RAW_BODY;
        end
      end
    end

    if (do_ml_body) begin
      if (ch == CH_EOF) begin
        st            = ST_DONE;
        nxt_ctl.phase = PH_IDLE;
      end else begin
        tin = 1'b1;
        if (ch == CH_QUOTE) begin
          nxt_ctl.quote_run = 2'd1;
          nxt_ctl.phase     = PH_ML_CLOSE;
        end else begin
          nxt_ctl.phase = PH_ML_BODY;
        end
      end
    end

    res.status   = st;
    res.in_token = tin;
    res.skipped  = skip;
    res.kind     = (((st == ST_SCAN) || (st == ST_DONE)) && !skip) ? nxt_ctl.token_kind
                                                                  : KIND_CMT;
  end

endmodule

// File: hdl/nested_comment_raw_string_lexer.sv
// top level of the nested comment, raw string and triple-quoted string lexer
//
// One character enters per item and one result item leaves for each, in order.
// An accepted character is held in an input register; when the result register
// is free or being drained, the scan step logic updates the scan state and
// writes the result register. The block sustains one character per cycle while
// out_ready stays high: the only loop is the scan state register around the
// combinational step logic. The input stage keeps accepting while a finished
// result waits for out_ready, until both stages are full. There are no memories
// and no clearing pass; the block is ready right after reset.
module nested_comment_raw_string_lexer import nclex_pkg::*; #(
  parameter int MAX_NEST = MAX_NEST_DEF,
  parameter int MAX_HASH = MAX_HASH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  // character input channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_start_scan,
  input  logic [7:0] in_ch,
  input  logic [2:0] in_allowed_kinds,
  // result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_status,
  output logic [1:0] out_kind,
  output logic       out_char_in_token,
  output logic       out_char_skipped
);

  localparam int NEST_W = $clog2(MAX_NEST + 1);
  localparam int HASH_W = $clog2(MAX_HASH + 1);

  // input register
  logic              s1_valid_r;
  logic              s1_start_r;
  logic [7:0]        s1_ch_r;
  logic [2:0]        s1_kinds_r;

  // scan state
  ctl_t              ctl_r;
  ctl_t              ctl_nxt;
  logic [NEST_W-1:0] depth_r;
  logic [NEST_W-1:0] depth_nxt;
  logic [HASH_W-1:0] open_r;
  logic [HASH_W-1:0] open_nxt;
  logic [HASH_W-1:0] close_r;
  logic [HASH_W-1:0] close_nxt;

  // result register
  logic              out_valid_r;
  res_t              res_r;
  res_t              res_nxt;

  logic              s1_adv;

  // the held item moves on when the result register is free or being drained
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  nclex_step #(
    .MAX_NEST(MAX_NEST),
    .MAX_HASH(MAX_HASH)
  ) u_step (
    .start_scan   (s1_start_r),
    .ch           (s1_ch_r),
    .allowed_kinds(s1_kinds_r),
    .cur_ctl      (ctl_r),
    .cur_depth    (depth_r),
    .cur_open     (open_r),
    .cur_close    (close_r),
    .nxt_ctl      (ctl_nxt),
    .nxt_depth    (depth_nxt),
    .nxt_open     (open_nxt),
    .nxt_close    (close_nxt),
    .res          (res_nxt)
  );

  // control and scan state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r       <= 1'b0;
      out_valid_r      <= 1'b0;
      ctl_r.phase      <= PH_IDLE;
      ctl_r.token_kind <= KIND_CMT;
      ctl_r.kind_mask  <= 3'd0;
      ctl_r.quote_run  <= 2'd0;
      depth_r          <= '0;
      open_r           <= '0;
      close_r          <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv) begin
        ctl_r       <= ctl_nxt;
        depth_r     <= depth_nxt;
        open_r      <= open_nxt;
        close_r     <= close_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_start_r <= in_start_scan;
      s1_ch_r    <= in_ch;
      s1_kinds_r <= in_allowed_kinds;
    end
    if (s1_adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = res_r.status;
  assign out_kind          = res_r.kind;
  assign out_char_in_token = res_r.in_token;
  assign out_char_skipped  = res_r.skipped;

  // a failed or finished token leaves the scanner idle
  a_end_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && ((res_nxt.status == ST_DONE) || (res_nxt.status == ST_NONE))
    |=> (ctl_r.phase == PH_IDLE))
    else $error("scan state not idle after token end");

  // no token never claims the character and carries no kind
  a_none_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_NONE) |-> !out_char_in_token && (out_kind == KIND_CMT))
    else $error("no-token item with token fields set");

  // a start item never reports idle
  a_start_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_start_r |-> (res_nxt.status != ST_IDLE))
    else $error("start item reported idle");

  // counters stay within their limits
  a_limits: assert property (@(posedge clk) disable iff (!rst_n)
    (depth_r <= NEST_W'(MAX_NEST)) && (open_r <= HASH_W'(MAX_HASH)) && (close_r <= open_r))
    else $error("nesting depth or hash count out of range");

endmodule

// File: tb/sv/nclex_checker.sv
// checker for the lexer: watches both channels, predicts each result item and compares
module nclex_checker import nclex_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic       in_start_scan,
  input  logic [7:0] in_ch,
  input  logic [2:0] in_allowed_kinds,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [1:0] out_status,
  input  logic [1:0] out_kind,
  input  logic       out_char_in_token,
  input  logic       out_char_skipped,
  output int         n_fail,
  output int         n_pending
);

  // predicted scan state
  phase_t     phase;
  logic [1:0] tok_kind;
  logic [2:0] kinds_ok;
  logic [7:0] depth;
  logic [4:0] hashes_open;
  logic [4:0] hashes_closed;
  logic [1:0] quotes;

  res_t lex_res;
  res_t lexed_results[$];
  int   n_results;

  task automatic end_token(input logic keep);
    lex_res.status   = ST_DONE;
    lex_res.in_token = keep;
    phase            = PH_IDLE;
  endtask

  task automatic reject_token();
    lex_res.status   = ST_NONE;
    lex_res.in_token = 1'b0;
    phase            = PH_IDLE;
  endtask

  // stage 0 tries all kinds, stage 1 skips the comment, stage 2 only the multiline string
  task automatic pick_kind(input int stage, input logic [7:0] c);
    if (stage == 0 && kinds_ok[MASK_CMT] && c == CH_SLASH) begin
      tok_kind = KIND_CMT; lex_res.in_token = 1'b1; phase = PH_CMT_OPEN;
    end else if (stage <= 1 && kinds_ok[MASK_RAW] && c == CH_R) begin
      tok_kind = KIND_RAW; lex_res.in_token = 1'b1; hashes_open = '0; phase = PH_RAW_HASH;
    end else if (kinds_ok[MASK_ML] && c == CH_QUOTE) begin
      tok_kind = KIND_ML; lex_res.in_token = 1'b1; quotes = 2'd1; phase = PH_ML_OPEN;
    end else begin
      reject_token();
    end
  endtask

  task automatic comment_body(input logic [7:0] c);
    phase = PH_CMT_BODY;
    if (c == CH_EOF) begin
      end_token(1'b0);
    end else begin
      lex_res.in_token = 1'b1;
      if (c == CH_SLASH) phase = PH_CMT_SLASH;
      else if (c == CH_STAR) phase = PH_CMT_STAR;
    end
  endtask

  task automatic raw_body(input logic [7:0] c);
    phase = PH_RAW_BODY;
    if (c == CH_EOF) begin
      end_token(1'b0);
    end else begin
      lex_res.in_token = 1'b1;
      if (c == CH_QUOTE) begin
        hashes_closed = '0; phase = PH_RAW_CLOSE;
      end
    end
  endtask

  task automatic ml_body(input logic [7:0] c);
    phase = PH_ML_BODY;
    if (c == CH_EOF) begin
      end_token(1'b0);
    end else begin
      lex_res.in_token = 1'b1;
      if (c == CH_QUOTE) begin
        quotes = 2'd1; phase = PH_ML_CLOSE;
      end
    end
  endtask

  // one character through the scan, result left in lex_res
  task automatic lex_char(input logic start, input logic [7:0] c, input logic [2:0] kinds);
    lex_res = '0;
    lex_res.status = ST_SCAN;
    if (start) begin
      kinds_ok      = kinds;
      phase         = PH_LEAD;
      tok_kind      = KIND_CMT;
      depth         = '0;
      hashes_open   = '0;
      hashes_closed = '0;
      quotes        = '0;
    end
    case (phase)
      PH_LEAD: begin
        if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) lex_res.skipped = 1'b1;
        else pick_kind(0, c);
      end
      PH_CMT_OPEN: begin
        if (c == CH_STAR) begin
          lex_res.in_token = 1'b1; depth = 8'd1; phase = PH_CMT_BODY;
        end else begin
          pick_kind(1, c);
        end
      end
      PH_CMT_BODY: comment_body(c);
      PH_CMT_SLASH: begin
        if (c == CH_STAR) begin
          lex_res.in_token = 1'b1;
          if (int'(depth) < MAX_NEST_DEF) depth++;
          phase = PH_CMT_BODY;
        end else begin
          comment_body(c);
        end
      end
      PH_CMT_STAR: begin
        if (c == CH_SLASH) begin
          if (depth <= 8'd1) begin
            depth = '0;
            end_token(1'b1);
          end else begin
            depth--; lex_res.in_token = 1'b1; phase = PH_CMT_BODY;
          end
        end else begin
          comment_body(c);
        end
      end
      PH_RAW_HASH: begin
        if (c == CH_HASH) begin
          lex_res.in_token = 1'b1;
          if (int'(hashes_open) < MAX_HASH_DEF) hashes_open++;
          else phase = PH_RAW_OVER;
        end else if (c == CH_QUOTE) begin
          lex_res.in_token = 1'b1; phase = PH_RAW_BODY;
        end else begin
          pick_kind(2, c);
        end
      end
      PH_RAW_OVER: pick_kind(2, c);
      PH_RAW_BODY: raw_body(c);
      PH_RAW_CLOSE: begin
        if (hashes_closed < hashes_open && c == CH_HASH) begin
          lex_res.in_token = 1'b1; hashes_closed++;
        end else if (hashes_closed == hashes_open && c != CH_HASH) begin
          end_token(1'b0);
        end else begin
          raw_body(c);
        end
      end
      PH_ML_OPEN: begin
        if (c == CH_QUOTE) begin
          lex_res.in_token = 1'b1;
          if (quotes >= 2'd2) phase = PH_ML_BODY;
          else quotes++;
        end else begin
          reject_token();
        end
      end
      PH_ML_BODY: ml_body(c);
      PH_ML_CLOSE: begin
        if (c == CH_QUOTE) begin
          if (quotes >= 2'd2) end_token(1'b1);
          else begin
            lex_res.in_token = 1'b1; quotes++;
          end
        end else begin
          ml_body(c);
        end
      end
      default: begin
        phase = PH_IDLE;
        lex_res.status = ST_IDLE;
      end
    endcase
    // kind only carries meaning while scanning or on a finished token
    if (lex_res.status > ST_DONE || lex_res.skipped) lex_res.kind = '0;
    else lex_res.kind = tok_kind;
  endtask

  task automatic report_fault(input string msg);
    $display("tb: %s", msg);
    n_fail++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_fault($sformatf("result %0d %s mismatch: got %0d, want %0d",
                             n_results, name, got, want));
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      phase         = PH_IDLE;
      tok_kind      = '0;
      kinds_ok      = '0;
      depth         = '0;
      hashes_open   = '0;
      hashes_closed = '0;
      quotes        = '0;
      n_fail        = 0;
      n_results     = 0;
      lexed_results.delete();
    end else begin
      if (in_valid && in_ready) begin
        lex_char(in_start_scan, in_ch, in_allowed_kinds);
        lexed_results.push_back(lex_res);
      end
      if (out_valid && out_ready) begin
        if (lexed_results.size() == 0) begin
          report_fault($sformatf("result %0d arrived with nothing expected", n_results));
        end else begin
          want = lexed_results.pop_front();
          check_field("status", int'(out_status), int'(want.status));
          check_field("kind", int'(out_kind), int'(want.kind));
          check_field("char_in_token", int'(out_char_in_token), int'(want.in_token));
          check_field("char_skipped", int'(out_char_skipped), int'(want.skipped));
        end
        n_results++;
      end
    end
    n_pending = lexed_results.size();
  end

endmodule

// File: tb/sv/testbench.sv
// top of the lexer testbench: clock, reset, character stimulus and the verdict
module testbench;
  import nclex_pkg::*;

  localparam int ITEM_TARGET = 1250;
  localparam int CALM_FROM   = 1100;     // no idling on either side past this item
  localparam int CYCLE_LIMIT = 300000;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic       in_start_scan;
  logic [7:0] in_ch;
  logic [2:0] in_allowed_kinds;
  logic       out_valid;
  logic       out_ready;
  logic [1:0] out_status;
  logic [1:0] out_kind;
  logic       out_char_in_token;
  logic       out_char_skipped;

  int n_fail;
  int n_pending;
  int n_sent;
  int n_cycles;
  int idle_pct;          // chance in percent that either side starts an idle burst
  logic calm;

  // the scan being written: its mask and whether the next char opens it
  logic       opening;
  logic [2:0] scan_kinds;

  logic [7:0] ws_chars[4]  = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};
  logic [7:0] key_chars[8] = '{CH_SLASH, CH_STAR, CH_HASH, CH_QUOTE,
                               CH_R, CH_EOF, CH_SPACE, CH_LF};

  nested_comment_raw_string_lexer i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_start_scan     (in_start_scan),
    .in_ch             (in_ch),
    .in_allowed_kinds  (in_allowed_kinds),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_kind          (out_kind),
    .out_char_in_token (out_char_in_token),
    .out_char_skipped  (out_char_skipped)
  );

  nclex_checker i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_start_scan     (in_start_scan),
    .in_ch             (in_ch),
    .in_allowed_kinds  (in_allowed_kinds),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_kind          (out_kind),
    .out_char_in_token (out_char_in_token),
    .out_char_skipped  (out_char_skipped),
    .n_fail            (n_fail),
    .n_pending         (n_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the handshake hangs
  initial n_cycles = 0;
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // one item on the input channel; called and returns at a falling edge
  task automatic put_char(input logic st, input logic [7:0] c, input logic [2:0] k);
    if (!calm && $urandom_range(1, 100) <= idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_start_scan    <= st;
    in_ch            <= c;
    in_allowed_kinds <= k;
    // hold the item until the edge that takes it
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    n_sent++;
  endtask

  // a char of the current scan; the mask only matters on the opening char
  task automatic put_tok(input logic [7:0] c);
    put_char(opening, c, opening ? scan_kinds : 3'($urandom_range(0, 7)));
    opening = 1'b0;
  endtask

  // open a scan, sometimes behind a bit of leading whitespace
  task automatic begin_scan(input logic [2:0] k);
    opening    = 1'b1;
    scan_kinds = k;
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) put_tok(ws_chars[$urandom_range(0, 3)]);
  endtask

  // mostly a mask that lets the wanted kind through, now and then any mask
  function automatic logic [2:0] kinds_with(input int b);
    if ($urandom_range(0, 4) == 0) return 3'($urandom_range(0, 7));
    return 3'($urandom_range(0, 7)) | (3'b001 << b);
  endfunction

  // a body char that none of the token rules look at
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (c == CH_SLASH || c == CH_STAR || c == CH_QUOTE || c == CH_HASH);
    return c;
  endfunction

  // nested comment; the deep one runs past the nesting limit and then closes
  // exactly as many levels as the saturated depth holds
  task automatic write_comment(input bit deep);
    int lvl;
    begin_scan(deep ? 3'b111 : kinds_with(MASK_CMT));
    put_tok(CH_SLASH);
    put_tok(CH_STAR);
    lvl = 1;
    if (deep) begin
      repeat (MAX_NEST_DEF + 1) begin
        put_tok(CH_SLASH);
        put_tok(CH_STAR);
      end
      repeat (MAX_NEST_DEF) begin
        put_tok(CH_STAR);
        put_tok(CH_SLASH);
      end
    end else begin
      repeat ($urandom_range(0, 12)) begin
        case ($urandom_range(0, 5))
          0: if (lvl < 6) begin
            put_tok(CH_SLASH);
            put_tok(CH_STAR);
            lvl++;
          end
          1: if (lvl > 1) begin
            put_tok(CH_STAR);
            put_tok(CH_SLASH);
            lvl--;
          end
          2: begin
            // star or slash that is not part of a pair
            put_tok($urandom_range(0, 1) ? CH_STAR : CH_SLASH);
            put_tok(plain_char());
          end
          default: put_tok(plain_char());
        endcase
      end
      case ($urandom_range(0, 7))
        0: put_tok(CH_EOF);
        1: ;                        // left open, the next scan restarts
        default: begin
          repeat (lvl) begin
            put_tok(CH_STAR);
            put_tok(CH_SLASH);
          end
        end
      endcase
    end
  endtask

  // raw string with n hashes; body quotes carry runs that must not close it
  task automatic write_raw();
    int n;
    int k;
    begin_scan(kinds_with(MASK_RAW));
    if ($urandom_range(0, 7) == 0) put_tok(CH_SLASH);    // lone slash falls through
    put_tok(CH_R);
    if ($urandom_range(0, 6) == 0) n = $urandom_range(MAX_HASH_DEF - 1, MAX_HASH_DEF + 1);
    else n = $urandom_range(0, 3);
    repeat (n) put_tok(CH_HASH);
    put_tok(CH_QUOTE);
    repeat ($urandom_range(0, 10)) begin
      if ($urandom_range(0, 3) == 0) begin
        // short run, or one that overruns the opening count
        if (n > 0 && $urandom_range(0, 1)) k = $urandom_range(0, n - 1);
        else k = n + $urandom_range(1, 2);
        put_tok(CH_QUOTE);
        repeat (k) put_tok(CH_HASH);
      end
      put_tok(plain_char());
    end
    case ($urandom_range(0, 7))
      0: put_tok(CH_EOF);
      1: ;
      default: begin
        put_tok(CH_QUOTE);
        repeat (n) put_tok(CH_HASH);
        put_tok($urandom_range(0, 3) == 0 ? CH_EOF : plain_char());
      end
    endcase
  endtask

  // triple-quoted string with stray single and double quotes inside
  task automatic write_ml();
    begin_scan(kinds_with(MASK_ML));
    repeat (3) put_tok(CH_QUOTE);
    repeat ($urandom_range(0, 10)) begin
      case ($urandom_range(0, 4))
        0: put_tok(CH_QUOTE);
        1: begin
          put_tok(CH_QUOTE);
          put_tok(CH_QUOTE);
        end
        default: ;
      endcase
      put_tok(plain_char());
    end
    case ($urandom_range(0, 7))
      0: put_tok(CH_EOF);
      1: ;
      default: repeat (3) put_tok(CH_QUOTE);
    endcase
  endtask

  // broken or random scans, rich in the chars the lexer reacts to
  task automatic write_noise();
    begin_scan(3'($urandom_range(0, 7)));
    repeat ($urandom_range(1, 6)) begin
      if ($urandom_range(0, 1)) put_tok(key_chars[$urandom_range(0, 7)]);
      else put_tok(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_directed();
    // no scan open: idle result
    put_char(1'b0, 8'hFF, 3'd0);
    // whitespace, lone slash that turns into a raw string, a closing run
    // followed by another hash, then the real close on the next char
    put_char(1'b1, CH_LF, 3'd7);
    put_char(1'b0, CH_SLASH, 3'd0);
    put_char(1'b0, CH_R, 3'd0);
    put_char(1'b0, CH_HASH, 3'd0);
    put_char(1'b0, CH_QUOTE, 3'd0);
    put_char(1'b0, CH_QUOTE, 3'd0);
    put_char(1'b0, CH_HASH, 3'd0);
    put_char(1'b0, CH_HASH, 3'd0);
    put_char(1'b0, CH_QUOTE, 3'd0);
    put_char(1'b0, CH_HASH, 3'd0);
    put_char(1'b0, 8'h79, 3'd0);
    // comment nested one level, abandoned by a restart
    put_char(1'b1, CH_SLASH, 3'd1);
    put_char(1'b0, CH_STAR, 3'd0);
    put_char(1'b0, CH_SLASH, 3'd0);
    put_char(1'b0, CH_STAR, 3'd0);
    put_char(1'b0, CH_STAR, 3'd0);
    put_char(1'b0, CH_SLASH, 3'd0);
    // empty triple-quoted string, closed on its last quote
    put_char(1'b1, CH_QUOTE, 3'd4);
    repeat (5) put_char(1'b0, CH_QUOTE, 3'd7);
    // end of input before any token
    put_char(1'b1, CH_EOF, 3'd7);
  endtask

  // result side: ready with random stall bursts, steady once calm
  initial begin
    int hold;
    hold = 0;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (calm || hold == 0) begin
        out_ready <= 1'b1;
        if (!calm && $urandom_range(1, 100) <= idle_pct) hold = $urandom_range(1, 10);
      end else begin
        out_ready <= 1'b0;
        hold--;
      end
    end
  end

  initial begin
    bit drained;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_start_scan    = 1'b0;
    in_ch            = '0;
    in_allowed_kinds = '0;
    calm             = 1'b0;
    idle_pct         = 15;
    n_sent           = 0;
    opening          = 1'b0;
    scan_kinds       = '0;
    drained          = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    run_directed();
    write_comment(1'b1);

    while (n_sent < ITEM_TARGET) begin
      if (n_sent >= CALM_FROM) calm = 1'b1;
      // once, halfway: let the block run dry before going on
      if (!drained && n_sent >= ITEM_TARGET / 2) begin
        in_valid <= 1'b0;
        while (n_pending != 0) @(negedge clk);
        @(negedge clk);
        drained = 1'b1;
      end
      // stretches with and without idling
      idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
      case ($urandom_range(0, 9))
        0, 1, 2: write_comment(1'b0);
        3, 4, 5: write_raw();
        6, 7, 8: write_ml();
        default: write_noise();
      endcase
      // chars between scans are idle unless the last scan was left open
      if ($urandom_range(0, 4) == 0)
        put_char(1'b0, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
    end

    in_valid <= 1'b0;
    while (n_pending != 0) @(negedge clk);
    // wait on so a stray result still shows up
    repeat (8) @(negedge clk);
    if (n_fail == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
